// File: design/ifp_pkg.sv
// Package for the IPv6 fragment planner: action codes, sequencer states,
// queue command and result types, and fixed header sizes.
// No dependencies.
package ifp_pkg;

  localparam logic [15:0] IPV6_HDR_BYTES = 16'd40;
  localparam logic [15:0] FRAG_HDR_BYTES = 16'd8;
  localparam logic [15:0] HDRS_BYTES     = 16'd48;
  localparam logic [15:0] TOO_BIG_DEDUCT = 16'd28;
  localparam logic [15:0] MIN_MTU        = 16'd1280;
  localparam logic [13:0] MAX_OFFSET     = 14'd8191;
  localparam int          QDEPTH         = 2;
  localparam int          QPTR_W         = $clog2(QDEPTH);
  localparam int          QCNT_W         = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ACT_WHOLE  = 2'd0,
    ACT_FRAG   = 2'd1,
    ACT_TOOBIG = 2'd2,
    ACT_DROP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CUT,
    ST_DROP
  } state_e;

  typedef struct packed {
    action_e     kind;
    logic [15:0] rep_mtu;
    logic [15:0] maxp;
    logic [12:0] off0;
    logic        more_final;
    logic        fresh;
    logic [15:0] p1;
    logic [15:0] p2;
    logic        p2_bad;
  } cmd_t;

  typedef struct packed {
    action_e     action;
    logic [12:0] frag_offset;
    logic [15:0] frag_bytes;
    logic        more_frags;
    logic        from_first_part;
    logic [15:0] part_start;
    logic        new_frag_header;
    logic [15:0] reported_mtu;
    logic        last;
  } res_t;

endpackage

// File: design/ipv6_fragment_planner.sv
// Top level of the IPv6 fragment planner: front classifier, command queue
// and fragment sequencer. Uses ifp_pkg, ifp_front, ifp_queue, ifp_back.
//
// Usage: one request per outgoing packet arrives on the input channel
// (in_valid_i / in_stall_o); it is taken at an edge with valid high and
// stall low. Results leave on the output channel (out_valid_o /
// out_stall_i), one per cycle at most, with last_o on the final result
// of each request's run. The MTU register is written through cfg_we_i /
// cfg_wdata_i; values below 1280 act as 1280.
// Path: a request sent whole, answered too-big or dropped at once passes
// through the command queue and the output register; a fragmented request
// is first loaded into the sequencer, which then gives one fragment per
// cycle while the output is not stalled (up to 56 results).
// Throughput: single-result requests sustain one per cycle while the output
// is not stalled; a fragmented request holds the sequencer for its load and results.
// A two-entry command queue lets the front take requests while the
// sequencer works; in_stall_o rises when the queue is full.
// When out_stall_i is high while out_valid_o is high, the output register and sequencer hold.
// Reset empties the queue, idles the sequencer, clears out_valid_o and
// sets the MTU to 1280.
module ipv6_fragment_planner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        has_frag_header_i,
  input  logic [12:0] frag_offset_in_i,
  input  logic        more_frags_in_i,
  input  logic [15:0] first_part_bytes_i,
  input  logic [15:0] second_part_bytes_i,
  input  logic        dont_fragment_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [12:0] frag_offset_o,
  output logic [15:0] frag_bytes_o,
  output logic        more_frags_o,
  output logic        from_first_part_o,
  output logic [15:0] part_start_o,
  output logic        new_frag_header_o,
  output logic [15:0] reported_mtu_o,
  output logic        last_o
);
  import ifp_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;
  res_t res;

  ifp_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .has_frag_header_i   (has_frag_header_i),
    .frag_offset_in_i    (frag_offset_in_i),
    .more_frags_in_i     (more_frags_in_i),
    .first_part_bytes_i  (first_part_bytes_i),
    .second_part_bytes_i (second_part_bytes_i),
    .dont_fragment_i     (dont_fragment_i),
    .q_full_i            (q_full),
    .q_push_o            (q_push),
    .q_cmd_o             (push_cmd)
  );

  ifp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ifp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign action_o          = res.action;
  assign frag_offset_o     = res.frag_offset;
  assign frag_bytes_o      = res.frag_bytes;
  assign more_frags_o      = res.more_frags;
  assign from_first_part_o = res.from_first_part;
  assign part_start_o      = res.part_start;
  assign new_frag_header_o = res.new_frag_header;
  assign reported_mtu_o    = res.reported_mtu;
  assign last_o            = res.last;

endmodule

// File: design/ifp_front.sv
// Front end of the IPv6 fragment planner: MTU register, size check and
// classification of each request into a queue command. Uses ifp_pkg.
module ifp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          has_frag_header_i,
  input  logic [12:0]   frag_offset_in_i,
  input  logic          more_frags_in_i,
  input  logic [15:0]   first_part_bytes_i,
  input  logic [15:0]   second_part_bytes_i,
  input  logic          dont_fragment_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output ifp_pkg::cmd_t q_cmd_o
);
  import ifp_pkg::*;

  logic [15:0] mtu_q;
  logic [15:0] mtu_eff;
  logic [17:0] total;
  logic [15:0] room;
  logic        more_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= MIN_MTU;
    end else if (cfg_we_i) begin
      mtu_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    mtu_eff    = (mtu_q < MIN_MTU) ? MIN_MTU : mtu_q;
    total      = {2'b00, IPV6_HDR_BYTES}
               + (has_frag_header_i ? {2'b00, FRAG_HDR_BYTES} : 18'd0)
               + {2'b00, first_part_bytes_i} + {2'b00, second_part_bytes_i};
    room       = mtu_eff - HDRS_BYTES;
    more_final = has_frag_header_i & more_frags_in_i;

    q_cmd_o            = '0;
    q_cmd_o.maxp       = {room[15:3], 3'b000};
    q_cmd_o.off0       = has_frag_header_i ? frag_offset_in_i : 13'd0;
    q_cmd_o.more_final = more_final;
    q_cmd_o.fresh      = ~has_frag_header_i;
    q_cmd_o.p1         = first_part_bytes_i;
    q_cmd_o.p2         = second_part_bytes_i;
    q_cmd_o.p2_bad     = more_final & (second_part_bytes_i[2:0] != 3'd0);
    priority if (total <= {2'b00, mtu_eff}) begin
      q_cmd_o.kind = ACT_WHOLE;
    end else if (dont_fragment_i) begin
      q_cmd_o.kind    = ACT_TOOBIG;
      q_cmd_o.rep_mtu = mtu_eff - TOO_BIG_DEDUCT;
    end else if (first_part_bytes_i[2:0] != 3'd0) begin
      q_cmd_o.kind = ACT_DROP;
    end else begin
      q_cmd_o.kind = ACT_FRAG;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

endmodule

// File: design/ifp_queue.sv
// Short command queue between front and back of the IPv6 fragment planner.
// Uses ifp_pkg.
module ifp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ifp_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output ifp_pkg::cmd_t cmd_o,
  output logic          full_o,
  output logic          empty_o
);
  import ifp_pkg::*;

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o   = entry_q[rd_ptr_q];
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

// File: design/ifp_back.sv
// Back end of the IPv6 fragment planner: sequencer that cuts payload parts into
// fragments, one result per cycle unless stalled, into the output register. Uses ifp_pkg.
module ifp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  ifp_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ifp_pkg::res_t res_o
);
  import ifp_pkg::*;

  state_e      state_q, state_d;
  cmd_t        cur_q, cur_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] pos_q, pos_d;
  logic [13:0] off_q, off_d;
  logic        first_q, first_d;
  logic        out_valid_q;
  res_t        res_q, res_d;
  logic        load;
  logic        emit;
  logic [15:0] len;
  logic [15:0] rem_left;
  logic        more_after;

  assign load = ~out_valid_q | ~out_stall_i;

  always_comb begin
    len        = (rem_q < cur_q.maxp) ? rem_q : cur_q.maxp;
    rem_left   = rem_q - len;
    more_after = first_q ? ((cur_q.p2 != 16'd0) | cur_q.more_final) : cur_q.more_final;

    state_d = state_q;
    cur_d   = cur_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    off_d   = off_q;
    first_d = first_q;
    res_d   = '0;
    emit    = 1'b0;
    q_pop_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (load && !q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.kind == ACT_FRAG) begin
            cur_d = q_cmd_i;
            off_d = {1'b0, q_cmd_i.off0};
            pos_d = '0;
            priority if (q_cmd_i.p1 != 16'd0) begin
              first_d = 1'b1;
              rem_d   = q_cmd_i.p1;
              state_d = ST_CUT;
            end else if (q_cmd_i.p2_bad) begin
              state_d = ST_DROP;
            end else begin
              first_d = 1'b0;
              rem_d   = q_cmd_i.p2;
              state_d = ST_CUT;
            end
          end else begin
            emit               = 1'b1;
            res_d.action       = q_cmd_i.kind;
            res_d.reported_mtu = q_cmd_i.rep_mtu;
            res_d.last         = 1'b1;
          end
        end
      end
      ST_CUT: begin
        if (load) begin
          emit = 1'b1;
          if (off_q > MAX_OFFSET) begin
            res_d.action = ACT_DROP;
            res_d.last   = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            res_d.action          = ACT_FRAG;
            res_d.frag_offset     = off_q[12:0];
            res_d.frag_bytes      = len;
            res_d.more_frags      = (rem_q > cur_q.maxp) | more_after;
            res_d.from_first_part = first_q;
            res_d.part_start      = pos_q;
            res_d.new_frag_header = cur_q.fresh;
            rem_d = rem_left;
            pos_d = pos_q + len;
            off_d = off_q + {1'b0, len[15:3]};
            if (rem_left == 16'd0) begin
              priority if (!first_q || cur_q.p2 == 16'd0) begin
                res_d.last = 1'b1;
                state_d    = ST_IDLE;
              end else if (cur_q.p2_bad) begin
                state_d = ST_DROP;
              end else begin
                first_d = 1'b0;
                rem_d   = cur_q.p2;
                pos_d   = '0;
              end
            end
          end
        end
      end
      ST_DROP: begin
        if (load) begin
          emit         = 1'b1;
          res_d.action = ACT_DROP;
          res_d.last   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    rem_q   <= rem_d;
    pos_q   <= pos_d;
    off_q   <= off_d;
    first_q <= first_d;
    if (load && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// File: design/ifp_checker.sv
// Port-level checker for the IPv6 fragment planner, bound to the top level.
// Uses ifp_pkg.
module ifp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  action_o,
  input logic [15:0] frag_bytes_o,
  input logic [15:0] reported_mtu_o,
  input logic        last_o
);
  import ifp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o) && $stable(last_o))
    else $error("stalled result changed");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ACT_FRAG |-> last_o)
    else $error("non-fragment result not last");

  a_report_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ACT_TOOBIG |-> reported_mtu_o == 16'd0)
    else $error("reported MTU outside too-big reply");

  a_frag_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_FRAG |-> frag_bytes_o != 16'd0)
    else $error("empty fragment");

endmodule

bind ipv6_fragment_planner ifp_checker u_ifp_checker (.*);
